@@ design/emd_pkg.sv @@
`default_nettype none

package emd_pkg;

  // Highest field index; the index register is 8 bits wide
  localparam int MaxFields = 255;
  localparam logic [7:0] FieldLimit = (MaxFields > 255) ? 8'd255 : 8'(MaxFields);

  // Special characters of the framing
  localparam logic [7:0] CharBslash = 8'h5C;  // backslash
  localparam logic [7:0] CharPipe   = 8'h7C;  // '|'
  localparam logic [7:0] CharNl     = 8'h0A;  // newline
  localparam logic [7:0] CharN      = 8'h6E;  // 'n'
  localparam logic [7:0] CharZero   = 8'h30;  // '0'
  localparam logic [7:0] CharX      = 8'h78;  // 'x'
  localparam logic [7:0] CharNul    = 8'h00;

  // Event codes on the output channel
  typedef enum logic [2:0] {
    EV_DATA  = 3'd0,
    EV_ARG   = 3'd1,
    EV_DONE  = 3'd2,
    EV_DROP  = 3'd3,
    EV_ABORT = 3'd4
  } ev_kind_t;

  // Parser mode, one-hot
  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESCAPE = 4'b0010,
    MODE_HEX1   = 4'b0100,
    MODE_HEX2   = 4'b1000
  } mode_t;

  // Hex digit decode: valid flag and nibble value
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.valid = 1'b1;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.value = 4'(c - 8'h37);
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ design/escaped_message_deframer_unit.sv @@
// Escaped message deframer.
// Input channel (rx_valid / rx_stall / in_byte) takes one raw byte of a
// newline-framed message stream per word. Output channel (tx_valid / tx_stall
// / event_kind / data_byte / field_index) gives at most one event per input
// word: a decoded data byte with its field index, a new argument, message
// done or dropped (title empty), or an abort on a raw zero byte.
// Escape lead-ins, the 'x' of a hex escape, the first hex digit and an
// invalid hex pair give no event.
// A byte passes the input register, then the result register, before its
// event shows. Throughput: one byte per cycle while the receiver does not stall;
// the parser state is updated by combinational logic between the two registers.
// When the receiver stalls, the result register holds its word and the input
// register fills, after which rx_stall rises; no word is lost or repeated.
// Reset (synchronous, rst high) empties both registers and returns the
// parser to normal mode at field 0 with an empty title.
`default_nettype none

module escaped_message_deframer_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] in_byte,
  output logic            tx_valid,
  input  wire logic       tx_stall,
  output logic [2:0]      event_kind,
  output logic [7:0]      data_byte,
  output logic [7:0]      field_index
);
  import emd_pkg::*;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Parser state
  mode_t      mode, mode_next;
  logic [3:0] hex_nib, hex_nib_next;
  logic       hex_ok, hex_ok_next;
  logic       title_nonempty, title_nonempty_next;
  logic [7:0] cur_field, cur_field_next;

  // Result register
  ev_kind_t   ev_kind;
  logic [7:0] ev_data;
  logic [7:0] ev_field;

  // Decode outputs
  logic       res;
  ev_kind_t   res_kind;
  logic [7:0] res_data;
  logic [7:0] res_field;
  logic       data_emit;
  logic [7:0] data_val;
  hex_digit_t hd;
  logic       advance;
  logic       s1_load;

  // Pipeline moves when the result register is free or being drained
  assign advance  = !tx_valid || !tx_stall;
  // Input register takes a word when it is empty or its word moves on
  assign s1_load  = advance || !s1_valid;
  assign rx_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= rx_valid;
    end
    if (s1_load) begin
      s1_byte <= in_byte;
    end
  end

  // Decode one byte against the parser state
  always_comb begin
    mode_next           = mode;
    hex_nib_next        = hex_nib;
    hex_ok_next         = hex_ok;
    title_nonempty_next = title_nonempty;
    cur_field_next      = cur_field;
    res                 = 1'b0;
    res_kind            = EV_DATA;
    res_data            = 8'd0;
    res_field           = cur_field;
    data_emit           = 1'b0;
    data_val            = s1_byte;
    hd                  = hex_decode(s1_byte);

    if (s1_byte == CharNul) begin
      // raw zero aborts in any mode
      mode_next           = MODE_NORMAL;
      hex_nib_next        = 4'd0;
      hex_ok_next         = 1'b0;
      title_nonempty_next = 1'b0;
      cur_field_next      = 8'd0;
      res                 = 1'b1;
      res_kind            = EV_ABORT;
      res_field           = 8'd0;
    end else begin
      case (mode)
        MODE_ESCAPE: begin
          mode_next = MODE_NORMAL;
          if (s1_byte == CharX) begin
            mode_next = MODE_HEX1;
          end else begin
            data_emit = 1'b1;
            if (s1_byte == CharN) begin
              data_val = CharNl;
            end else if (s1_byte == CharZero) begin
              data_val = CharNul;
            end
          end
        end
        MODE_HEX1: begin
          hex_ok_next  = hd.valid;
          hex_nib_next = hd.valid ? hd.value : 4'd0;
          mode_next    = MODE_HEX2;
        end
        MODE_HEX2: begin
          mode_next   = MODE_NORMAL;
          hex_ok_next = 1'b0;
          if (hex_ok && hd.valid) begin
            data_emit = 1'b1;
            data_val  = {hex_nib, hd.value};
          end
        end
        MODE_NORMAL: begin
          if (s1_byte == CharBslash) begin
            mode_next = MODE_ESCAPE;
          end else if (s1_byte == CharPipe) begin
            if (cur_field < FieldLimit) begin
              cur_field_next = cur_field + 8'd1;
            end
            res       = 1'b1;
            res_kind  = EV_ARG;
            res_field = cur_field_next;
          end else if (s1_byte == CharNl) begin
            res                 = 1'b1;
            res_kind            = title_nonempty ? EV_DONE : EV_DROP;
            title_nonempty_next = 1'b0;
            cur_field_next      = 8'd0;
          end else begin
            data_emit = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_NORMAL;
        end
      endcase

      // data byte goes out under the current field
      if (data_emit) begin
        res      = 1'b1;
        res_kind = EV_DATA;
        res_data = data_val;
        if (cur_field == 8'd0) begin
          title_nonempty_next = 1'b1;
        end
      end
    end
  end

  // Parser state update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_NORMAL;
      hex_nib        <= 4'd0;
      hex_ok         <= 1'b0;
      title_nonempty <= 1'b0;
      cur_field      <= 8'd0;
    end else if (s1_valid && advance) begin
      mode           <= mode_next;
      hex_nib        <= hex_nib_next;
      hex_ok         <= hex_ok_next;
      title_nonempty <= title_nonempty_next;
      cur_field      <= cur_field_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (advance) begin
      tx_valid <= s1_valid && res;
    end
    if (advance) begin
      ev_kind  <= res_kind;
      ev_data  <= res_data;
      ev_field <= res_field;
    end
  end

  assign event_kind  = ev_kind;
  assign data_byte   = ev_data;
  assign field_index = ev_field;

endmodule

`default_nettype wire

@@ design/emd_checker.sv @@
`default_nettype none

module emd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_valid,
  input wire logic       rx_stall,
  input wire logic [7:0] in_byte,
  input wire logic       tx_valid,
  input wire logic       tx_stall,
  input wire logic [2:0] event_kind,
  input wire logic [7:0] data_byte,
  input wire logic [7:0] field_index
);
  import emd_pkg::*;

  // Output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !tx_valid)
    else $error("event word present after reset");

  // Only data events carry a byte
  a_data_only: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && event_kind != EV_DATA) |-> data_byte == 8'd0)
    else $error("nonzero data byte on a non-data event");

  // Abort reports field zero
  a_abort_field: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && event_kind == EV_ABORT) |-> field_index == 8'd0)
    else $error("abort with nonzero field index");

  // A raw zero byte taken from the input is followed by an abort event, unless the receiver stalled
  a_abort_cause: assert property (@(posedge clk) disable iff (rst)
    (rx_valid && !rx_stall && in_byte == 8'd0) |=> ##1
      (tx_valid && event_kind == EV_ABORT) || $past(tx_stall))
    else $error("raw zero byte did not abort");

  // Stalled event word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && tx_stall) |=> (tx_valid && $stable(event_kind)
      && $stable(data_byte) && $stable(field_index)))
    else $error("stalled event word changed");

endmodule

bind escaped_message_deframer_unit emd_checker u_emd_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_valid    (rx_valid),
  .rx_stall    (rx_stall),
  .in_byte     (in_byte),
  .tx_valid    (tx_valid),
  .tx_stall    (tx_stall),
  .event_kind  (event_kind),
  .data_byte   (data_byte),
  .field_index (field_index)
);

`default_nettype wire
